[hw/rtl/assert_macros.svh]
// assertion helpers, clocked on clk, disabled in reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define AVSM_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`define AVSM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[hw/rtl/avsm_pkg.sv]
package avsm_pkg;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD,
		ST_CHK,
		ST_DIV,
		ST_GAIN,
		ST_AMP,
		ST_WSIN,
		ST_WROM,
		ST_NHOLD,
		ST_NDEC,
		ST_NLVL,
		ST_MIX,
		ST_ACC,
		ST_NEXT,
		ST_OUT
	} avsm_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} avsm_div_sts_t;

	localparam logic       KIND_TRIGGER = 1'b1;
	localparam logic [2:0] SHAPE_SINE   = 3'd1;
	localparam logic [2:0] SHAPE_SQUARE = 3'd2;
	localparam logic [2:0] SHAPE_TRI    = 3'd3;
	localparam logic [2:0] SHAPE_NOISE  = 3'd4;

	localparam logic [15:0] LFSR_SEED   = 16'hACE1;
	localparam logic [16:0] NOISE_DECAY = 17'd32604;
	localparam logic [14:0] GAIN_UNITY  = 15'd16384;
	localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
	localparam int          GAIN_BITS   = 15;

endpackage

[hw/rtl/avsm_in_if.sv]
interface avsm_in_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [2:0]  shape;
	logic [31:0] phase_step;
	logic [11:0] peak_level;
	logic [19:0] attack_len;
	logic [19:0] decay_len;
	logic [19:0] sustain_len;
	logic [19:0] release_len;
	logic [15:0] noise_span;

	modport source (output valid, kind, shape, phase_step, peak_level, attack_len,
		decay_len, sustain_len, release_len, noise_span, input ready);
	modport sink (input valid, kind, shape, phase_step, peak_level, attack_len,
		decay_len, sustain_len, release_len, noise_span, output ready);
endinterface

[hw/rtl/avsm_out_if.sv]
interface avsm_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] mixed_sample;
	logic        [4:0]  active_voices;

	modport source (output valid, mixed_sample, active_voices, input ready);
	modport sink (input valid, mixed_sample, active_voices, output ready);
endinterface

[hw/rtl/avsm_div.sv]
// restoring divider, one quotient bit per cycle; numerator >> Q_W must be below den
module avsm_div #(
	parameter int DEN_W = 22,
	parameter int Q_W   = 15
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [DEN_W+Q_W-1:0]      num,
	input  logic [DEN_W-1:0]          den,
	output logic [Q_W-1:0]            quo,
	output avsm_pkg::avsm_div_sts_t   sts
);
	import avsm_pkg::*;

	localparam int CNT_W = $clog2(Q_W + 1);

	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [Q_W-1:0]   low_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             ge;

	always_comb begin
		trial = {rem_q, low_q[Q_W-1]};
		diff  = trial - {1'b0, den_q};
		ge    = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(Q_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num[DEN_W+Q_W-1:Q_W];
			low_q <= num[Q_W-1:0];
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			low_q <= {low_q[Q_W-2:0], ge};
		end
	end

	assign quo      = low_q;
	assign sts.busy = busy_q;
	assign sts.done = done_q;
endmodule

[hw/rtl/avsm_mem.sv]
// voice record store, one write and one registered read; unwritten entries read as zero
module avsm_mem #(
	parameter int WIDTH = 240,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	import avsm_pkg::*;

	logic [WIDTH-1:0] mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [WIDTH-1:0] rdata_q;
	logic             rvld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			rvld_q <= vld_q[raddr];
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rvld_q ? rdata_q : '0;
endmodule

[hw/rtl/adsr_voice_synth_mixer.sv]
// channel | dir | transaction
// item    | in  | kind 0 tick one sample, kind 1 load next voice slot
// result  | out | one mixed sample and voice count per tick
//
// Trigger: written to the slot from idle. Tick: visits all VOICES in turn; a
// sounding voice outside sustain also runs the bit-serial envelope divider, and
// sine and noise waves take extra states.
// Every multiply goes through one shared 32x17 multiplier.
// Reset clears all voice slots at once via valid bits; lfsr starts at 0xACE1.
// item.ready is high only while idle; a finished sample waits in the output
// register, and the next tick stalls at its end until that register is free.
module adsr_voice_synth_mixer #(
	parameter int VOICES       = 16,
	parameter int SINE_ENTRIES = 256,
	parameter int TIME_BITS    = 22
) (
	input  logic        clk,
	input  logic        arst_n,
	avsm_in_if.sink     item,
	avsm_out_if.source  result
);
	import avsm_pkg::*;
	`include "assert_macros.svh"

	localparam int AW     = VOICES > 1 ? $clog2(VOICES) : 1;
	localparam int T      = TIME_BITS;
	localparam int NUM_W  = T + GAIN_BITS;
	localparam int EW     = T > 22 ? T : 22;
	localparam int IW     = $clog2(SINE_ENTRIES + 1);
	localparam int SUM_W  = ($clog2(VOICES) + 14) > 16 ? ($clog2(VOICES) + 14) : 16;
	localparam int CW     = $clog2(VOICES + 1) < 5 ? 5 : $clog2(VOICES + 1);
	localparam logic [T-1:0] TIME_MAX = '1;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] step;
		logic [31:0] phase;
		logic [11:0] level;
		logic [T-1:0] age;
		logic [T-1:0] ea;
		logic [T-1:0] ed;
		logic [T-1:0] es;
		logic [T-1:0] er;
		logic [16:0] hold;
		logic        pol;
		logic [15:0] nlvl;
		logic [15:0] span;
	} voice_rec_t;

	localparam int REC_W = $bits(voice_rec_t);

	function automatic logic [15:0] sine_val(int k);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] e;
		x    = (64'(HALF_PI_Q30) * 64'(k)) / SINE_ENTRIES;
		x2   = (x * x) >> 30;
		term = x;
		sum  = x;
		term = ((term * x2) >> 30) / 6;
		sum  = sum - term;
		term = ((term * x2) >> 30) / 20;
		sum  = sum + term;
		term = ((term * x2) >> 30) / 42;
		sum  = sum - term;
		term = ((term * x2) >> 30) / 72;
		sum  = sum + term;
		term = ((term * x2) >> 30) / 110;
		sum  = sum - term;
		term = ((term * x2) >> 30) / 156;
		sum  = sum + term;
		e    = (sum * 64'd32767 + 64'd536870912) >> 30;
		if (e > 64'd32767) begin
			e = 64'd32767;
		end
		return e[15:0];
	endfunction

	logic [15:0] sine_rom [SINE_ENTRIES+1];
	for (genvar k = 0; k <= SINE_ENTRIES; k++) begin : g_rom
		localparam logic [15:0] V = sine_val(k);
		assign sine_rom[k] = V;
	end

	avsm_state_t st_q, st_d;

	logic [AW-1:0]          slot_q;
	logic [AW-1:0]          v_q;
	voice_rec_t             rec_q;
	voice_rec_t             rd_rec;
	voice_rec_t             trig_rec;
	logic [REC_W-1:0]       mem_rdata;
	logic                   mem_we;
	logic [AW-1:0]          mem_waddr;
	logic [REC_W-1:0]       mem_wdata;
	logic [15:0]            lfsr_q;
	logic [15:0]            lfsr_nx;
	logic [31:0]            mul_a;
	logic [16:0]            mul_b;
	logic [48:0]            mul_q;
	logic                   div_start;
	logic [NUM_W-1:0]       div_num;
	logic [T-1:0]           div_den;
	logic [GAIN_BITS-1:0]   div_quo;
	avsm_div_sts_t          div_sts;
	logic [GAIN_BITS-1:0]   gain_base_q;
	logic [GAIN_BITS-1:0]   gain_q;
	logic [12:0]            amp_q;
	logic [16:0]            wave_q;
	logic                   neg_q;
	logic [15:0]            rom_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [CW-1:0]          cnt_q;
	logic                   res_valid_q;
	logic signed [15:0]     res_sample_q;
	logic [4:0]             res_count_q;
	logic                   active;
	logic                   seg_att;
	logic                   seg_dec;
	logic                   seg_sus;
	logic [EW-1:0]          e1, e2, e3, e4;
	logic [31:0]            tri_d;
	logic [16:0]            tri_t;
	logic [IW-1:0]          sin_idx;
	logic [IW-1:0]          sin_addr;
	logic [14:0]            mag;
	logic signed [SUM_W-1:0] sum_nx;
	logic                   out_free;

	assign rd_rec   = voice_rec_t'(mem_rdata);
	assign lfsr_nx  = {lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5], lfsr_q[15:1]};
	assign out_free = !res_valid_q || result.ready;

	always_comb begin
		e1 = EW'(item.attack_len);
		e2 = e1 + EW'(item.decay_len);
		e3 = e2 + EW'(item.sustain_len);
		e4 = e3 + EW'(item.release_len);
		trig_rec       = '0;
		trig_rec.kind  = item.shape;
		trig_rec.step  = item.phase_step;
		trig_rec.level = item.peak_level;
		trig_rec.ea    = (e1 > EW'(TIME_MAX)) ? TIME_MAX : e1[T-1:0];
		trig_rec.ed    = (e2 > EW'(TIME_MAX)) ? TIME_MAX : e2[T-1:0];
		trig_rec.es    = (e3 > EW'(TIME_MAX)) ? TIME_MAX : e3[T-1:0];
		trig_rec.er    = (e4 > EW'(TIME_MAX)) ? TIME_MAX : e4[T-1:0];
		trig_rec.span  = item.noise_span;
	end

	always_comb begin
		active  = (rd_rec.kind >= SHAPE_SINE) && (rd_rec.kind <= SHAPE_NOISE) &&
			(rd_rec.age < rd_rec.er);
		seg_att = (rd_rec.ea != '0) && (rd_rec.age <= rd_rec.ea);
		seg_dec = !seg_att && (rd_rec.ed > rd_rec.ea) && (rd_rec.age <= rd_rec.ed);
		seg_sus = !seg_att && !seg_dec && (rd_rec.age <= rd_rec.es);
		if (seg_att) begin
			div_num = (NUM_W'(rd_rec.age) << 14) + (NUM_W'(rd_rec.age) << 13);
			div_den = rd_rec.ea;
		end else if (seg_dec) begin
			div_num = NUM_W'(rd_rec.ed - rd_rec.age) << 13;
			div_den = rd_rec.ed - rd_rec.ea;
		end else begin
			div_num = NUM_W'(rd_rec.er - rd_rec.age) << 14;
			div_den = rd_rec.er - rd_rec.es;
		end
	end

	always_comb begin
		tri_d    = (rec_q.phase > 32'h8000_0000) ? (32'd0 - rec_q.phase) : rec_q.phase;
		tri_t    = tri_d[31:15];
		sin_idx  = mul_q[30+IW-1:30];
		sin_addr = rec_q.phase[30] ? (IW'(SINE_ENTRIES) - sin_idx) : sin_idx;
		mag      = mul_q[29:15];
		sum_nx   = neg_q ? (sum_q - SUM_W'(mag)) : (sum_q + SUM_W'(mag));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d       = st_q;
		item.ready = 1'b0;
		div_start  = 1'b0;
		mem_we     = 1'b0;
		mem_waddr  = v_q;
		mem_wdata  = REC_W'(rec_q);
		mul_a      = {20'd0, rec_q.level};
		mul_b      = {2'd0, gain_q};
		case (st_q)
			ST_IDLE: begin
				item.ready = 1'b1;
				if (item.valid) begin
					if (item.kind == KIND_TRIGGER) begin
						mem_we    = 1'b1;
						mem_waddr = slot_q;
						mem_wdata = REC_W'(trig_rec);
					end else begin
						st_d = ST_RD;
					end
				end
			end
			ST_RD: st_d = ST_CHK;
			ST_CHK: begin
				if (!active) begin
					st_d = ST_NEXT;
				end else if (seg_sus) begin
					st_d = ST_GAIN;
				end else begin
					div_start = 1'b1;
					st_d      = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_sts.done) begin
					st_d = ST_GAIN;
				end
			end
			ST_GAIN: st_d = ST_AMP;
			ST_AMP: begin
				case (rec_q.kind)
					SHAPE_SINE: begin
						mul_a = {2'd0, rec_q.phase[29:0]};
						mul_b = 17'(SINE_ENTRIES);
						st_d  = ST_WSIN;
					end
					SHAPE_NOISE: begin
						mul_a = {16'd0, rec_q.span};
						mul_b = {1'b0, lfsr_nx};
						st_d  = (rec_q.hold == '0) ? ST_NHOLD : ST_NDEC;
					end
					default: st_d = ST_MIX;
				endcase
			end
			ST_WSIN: st_d = ST_WROM;
			ST_WROM: st_d = ST_MIX;
			ST_NHOLD: st_d = ST_NDEC;
			ST_NDEC: begin
				mul_a = {16'd0, rec_q.nlvl};
				mul_b = NOISE_DECAY;
				st_d  = ST_NLVL;
			end
			ST_NLVL: st_d = ST_MIX;
			ST_MIX: begin
				mul_a = {15'd0, wave_q};
				mul_b = {4'd0, amp_q};
				st_d  = ST_ACC;
			end
			ST_ACC: begin
				mem_we    = 1'b1;
				mem_wdata = REC_W'(rec_q);
				st_d      = ST_NEXT;
			end
			ST_NEXT: st_d = (v_q == AW'(VOICES - 1)) ? ST_OUT : ST_RD;
			ST_OUT: begin
				if (out_free) begin
					st_d = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q      <= '0;
			v_q         <= '0;
			lfsr_q      <= LFSR_SEED;
			cnt_q       <= '0;
			sum_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (st_q == ST_OUT && out_free) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (item.valid) begin
						if (item.kind == KIND_TRIGGER) begin
							slot_q <= (slot_q == AW'(VOICES - 1)) ? '0 : slot_q + AW'(1);
						end else begin
							v_q   <= '0;
							sum_q <= '0;
							cnt_q <= '0;
						end
					end
				end
				ST_AMP: begin
					if (rec_q.kind == SHAPE_NOISE && rec_q.hold == '0) begin
						lfsr_q <= lfsr_nx;
					end
				end
				ST_ACC: begin
					sum_q <= sum_nx;
					cnt_q <= cnt_q + CW'(1);
				end
				ST_NEXT: begin
					if (v_q != AW'(VOICES - 1)) begin
						v_q <= v_q + AW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		mul_q <= 49'(mul_a) * 49'(mul_b);
		case (st_q)
			ST_CHK: begin
				rec_q       <= rd_rec;
				gain_q      <= GAIN_UNITY;
				gain_base_q <= (seg_att) ? '0 : (seg_dec ? GAIN_UNITY : '0);
			end
			ST_DIV: begin
				if (div_sts.done) begin
					gain_q <= gain_base_q + div_quo;
				end
			end
			ST_AMP: begin
				amp_q <= mul_q[26:14];
				case (rec_q.kind)
					SHAPE_SQUARE: begin
						wave_q <= 17'd32768;
						neg_q  <= !(rec_q.phase > 32'h8000_0000);
					end
					SHAPE_TRI: begin
						if (tri_t >= 17'd32768) begin
							wave_q <= tri_t - 17'd32768;
							neg_q  <= 1'b0;
						end else begin
							wave_q <= 17'd32768 - tri_t;
							neg_q  <= 1'b1;
						end
					end
					SHAPE_NOISE: begin
						if (rec_q.hold != '0) begin
							rec_q.hold <= rec_q.hold - 17'd1;
						end
					end
					default: ;
				endcase
			end
			ST_WSIN: begin
				rom_q <= sine_rom[sin_addr];
				neg_q <= rec_q.phase[31];
			end
			ST_WROM: wave_q <= {1'b0, rom_q};
			ST_NHOLD: begin
				rec_q.hold <= {1'b0, mul_q[31:16]} + 17'd1;
				rec_q.pol  <= !rec_q.pol;
				rec_q.nlvl <= 16'd32768;
			end
			ST_NLVL: begin
				rec_q.nlvl <= mul_q[30:15];
				wave_q     <= {1'b0, mul_q[30:15]};
				neg_q      <= rec_q.pol;
			end
			ST_MIX: begin
				rec_q.phase <= rec_q.phase + rec_q.step;
				rec_q.age   <= rec_q.age + T'(1);
			end
			ST_OUT: begin
				if (out_free) begin
					if (sum_q > SUM_W'(32767)) begin
						res_sample_q <= 16'sd32767;
					end else if (sum_q < -SUM_W'(32767)) begin
						res_sample_q <= -16'sd32767;
					end else begin
						res_sample_q <= sum_q[15:0];
					end
					res_count_q <= (cnt_q > CW'(31)) ? 5'd31 : cnt_q[4:0];
				end
			end
			default: ;
		endcase
	end

	avsm_mem #(
		.WIDTH (REC_W),
		.DEPTH (VOICES)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (mem_we),
		.waddr  (mem_waddr),
		.wdata  (mem_wdata),
		.raddr  (v_q),
		.rdata  (mem_rdata)
	);

	avsm_div #(
		.DEN_W (T),
		.Q_W   (GAIN_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.quo    (div_quo),
		.sts    (div_sts)
	);

	assign result.valid         = res_valid_q;
	assign result.mixed_sample  = res_sample_q;
	assign result.active_voices = res_count_q;

	`AVSM_ASSERT_IMPL(a_ready_idle, item.ready, st_q == ST_IDLE)
	`AVSM_ASSERT_IMPL(a_cnt_bound, st_q == ST_OUT, cnt_q <= CW'(VOICES))
	`AVSM_ASSERT_NEXT(a_out_wait, st_q == ST_OUT && res_valid_q && !result.ready,
		st_q == ST_OUT)
	`AVSM_ASSERT_IMPL(a_div_idle_start, div_start, !div_sts.busy && st_q == ST_CHK)
endmodule
